>>> hw/rtl/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// shared types and constants of the sorted timer pool
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int POOL_SIZE = 512;
   localparam int PW        = $clog2(POOL_SIZE);
   localparam int IW        = 9;
   localparam int TW        = 32;
   localparam int BW        = 8;

   localparam logic [TW-1:0] NEVER = 32'hffff_ffff;
   localparam logic [PW-1:0] LAST  = PW'(POOL_SIZE - 1);

   typedef enum logic [1:0] {
      ST_FREE  = 2'd0,
      ST_ALLOC = 2'd1,
      ST_RUN   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      F_ALLOC     = 3'd0,
      F_FREE      = 3'd1,
      F_INIT      = 3'd2,
      F_SETTIME   = 3'd3,
      F_CANCEL    = 3'd4,
      F_CANCELALL = 3'd5
   } func_type;

   typedef struct packed {
      status_type     status;
      logic           mark;
      logic [BW-1:0]  buffer;
      logic [BW-1:0]  data;
   } meta_type;

   localparam int MW = $bits(meta_type);

   typedef struct packed {
      logic [TW-1:0] a;
      logic [TW-1:0] b;
   } alu_in_type;

   typedef struct packed {
      logic [TW-1:0] sum;
      logic          le;
   } alu_out_type;

endpackage

>>> hw/rtl/stp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module stp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/stp_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_alu
// shared 32-bit adder and unsigned less-or-equal compare
// ----------------------------------------------------------------------------
module stp_alu (
   input  stp_pkg::alu_in_type  alu_in,
   output stp_pkg::alu_out_type alu_out
);
   import stp_pkg::*;

   assign alu_out.sum = alu_in.a + alu_in.b;
   assign alu_out.le  = (alu_in.a <= alu_in.b);

endmodule

>>> hw/rtl/sorted_timer_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_pool
// deadline-ordered timer list behind a sentinel, one sequencer over three rams
// ----------------------------------------------------------------------------
// work: settime walks the list to its slot, cancel and free of a running entry
//   walk the list to unlink it, alloc scans the pool for a free entry, cancelall
//   scans the pool plus one unlink walk per running matched entry
// throughput: one item at a time; the list walk and the pool scan set it
// reset: a clearing pass sweeps every ram entry (entry 0 becomes
//   the running sentinel); no item is taken until it is over
module sorted_timer_pool (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_func,
   input  logic [8:0]             req_timer_index,
   input  logic [7:0]             req_buffer_id,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_auto_cancel,
   input  logic [31:0]            req_timeout,
   input  logic [31:0]            req_now_time,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_ok,
   output logic [8:0]             rsp_got_index,
   output logic [8:0]             rsp_head_index,
   output logic [31:0]            rsp_head_deadline
);
   import stp_pkg::*;

   // one-hot sequencer states
   typedef enum logic [11:0] {
      S_CLEAR    = 12'b0000_0000_0001,
      S_IDLE     = 12'b0000_0000_0010,
      S_META     = 12'b0000_0000_0100,
      S_INS_LINK = 12'b0000_0000_1000,
      S_INS_DL   = 12'b0000_0001_0000,
      S_INS_W2   = 12'b0000_0010_0000,
      S_UL_NEXT  = 12'b0000_0100_0000,
      S_UL_HT    = 12'b0000_1000_0000,
      S_UL_WALK  = 12'b0001_0000_0000,
      S_UL_FIN   = 12'b0010_0000_0000,
      S_SCAN     = 12'b0100_0000_0000,
      S_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   func_type       func_ff, func_in;
   logic [BW-1:0]  buf_ff, buf_in;
   logic [BW-1:0]  dat_ff, dat_in;
   logic           mark_ff, mark_in;
   logic [TW-1:0]  when_ff, when_in;
   logic [PW-1:0]  e_ff, e_in;
   meta_type       meta_ff, meta_in;
   logic [PW-1:0]  p_ff, p_in;
   logic [PW-1:0]  ne_ff, ne_in;
   logic [PW-1:0]  t_ff, t_in;
   logic [PW-1:0]  scan_ff, scan_in;
   logic [PW-1:0]  sa_ff, sa_in;
   logic           sv_ff, sv_in;
   logic [PW-1:0]  clr_ff, clr_in;
   logic           ok_ff, ok_in;
   logic [PW-1:0]  got_ff, got_in;
   logic [PW-1:0]  head_ff, head_in;
   logic [TW-1:0]  head_time_ff, head_time_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_ok_ff, rsp_ok_in;
   logic [PW-1:0]  rsp_got_ff, rsp_got_in;
   logic [PW-1:0]  rsp_head_ff, rsp_head_in;
   logic [TW-1:0]  rsp_time_ff, rsp_time_in;

   // ram ports
   logic           meta_we, dl_we, link_we;
   logic [PW-1:0]  meta_wa, dl_wa, link_wa;
   meta_type       meta_wd, meta_rd;
   logic [MW-1:0]  meta_rd_raw;
   logic [TW-1:0]  dl_wd, dl_rd;
   logic [PW-1:0]  link_wd, link_rd;
   logic [PW-1:0]  meta_ra, dl_ra, link_ra;

   alu_in_type     alu_in;
   alu_out_type    alu_out;

   logic [PW-1:0]  req_idx;
   logic           req_idx_ok;
   logic           hit;

   // status, mark, buffer and data of each entry
   stp_ram #(.WIDTH(MW), .DEPTH(POOL_SIZE)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (meta_wa),
      .wr_data (meta_wd),
      .rd_addr (meta_ra),
      .rd_data (meta_rd_raw)
   );
   assign meta_rd = meta_type'(meta_rd_raw);

   // deadline of each entry
   stp_ram #(.WIDTH(TW), .DEPTH(POOL_SIZE)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_wa),
      .wr_data (dl_wd),
      .rd_addr (dl_ra),
      .rd_data (dl_rd)
   );

   // next entry on the list
   stp_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_wa),
      .wr_data (link_wd),
      .rd_addr (link_ra),
      .rd_data (link_rd)
   );

   // one adder / comparator shared by every step
   stp_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   always_comb begin
      alu_in.a = when_ff;
      alu_in.b = dl_rd;
      if (state_ff == S_IDLE) begin
         // deadline = now + timeout, taken at acceptance
         alu_in.a = req_timeout;
         alu_in.b = req_now_time;
      end else if (state_ff == S_META) begin
         // front of list test against the cached head deadline
         alu_in.b = head_time_ff;
      end
   end

   assign req_idx    = PW'(req_timer_index);
   assign req_idx_ok = (req_timer_index != 9'd0) &&
                       ({1'b0, req_timer_index} < 10'(POOL_SIZE));
   assign req_ready  = (state_ff == S_IDLE);

   // cancelall match on the entry coming out of the scan
   assign hit = (meta_rd.status != ST_FREE) && meta_rd.mark &&
                (meta_rd.buffer == buf_ff);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      buf_in       = buf_ff;
      dat_in       = dat_ff;
      mark_in      = mark_ff;
      when_in      = when_ff;
      e_in         = e_ff;
      meta_in      = meta_ff;
      p_in         = p_ff;
      ne_in        = ne_ff;
      t_in         = t_ff;
      scan_in      = scan_ff;
      sa_in        = sa_ff;
      sv_in        = sv_ff;
      clr_in       = clr_ff;
      ok_in        = ok_ff;
      got_in       = got_ff;
      head_in      = head_ff;
      head_time_in = head_time_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_got_in   = rsp_got_ff;
      rsp_head_in  = rsp_head_ff;
      rsp_time_in  = rsp_time_ff;

      meta_we = 1'b0;
      meta_wa = e_ff;
      meta_wd = meta_ff;
      dl_we   = 1'b0;
      dl_wa   = e_ff;
      dl_wd   = when_ff;
      link_we = 1'b0;
      link_wa = e_ff;
      link_wd = t_ff;
      meta_ra = e_ff;
      dl_ra   = link_rd;
      link_ra = e_ff;

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // sweep: entry 0 is the running sentinel, linked to itself
            meta_we        = 1'b1;
            meta_wa        = clr_ff;
            meta_wd        = '0;
            meta_wd.status = (clr_ff == '0) ? ST_RUN : ST_FREE;
            dl_we          = 1'b1;
            dl_wa          = clr_ff;
            dl_wd          = NEVER;
            link_we        = 1'b1;
            link_wa        = clr_ff;
            link_wd        = '0;
            clr_in         = clr_ff + 1'b1;
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            meta_ra = req_idx;
            if (req_valid) begin
               func_in = func_type'(req_func);
               buf_in  = req_buffer_id;
               dat_in  = req_data_byte;
               mark_in = req_auto_cancel;
               when_in = alu_out.sum;
               e_in    = req_idx;
               ok_in   = 1'b0;
               got_in  = '0;
               sv_in   = 1'b0;
               case (func_type'(req_func))
                  F_ALLOC: begin
                     scan_in  = '0;
                     state_in = S_SCAN;
                  end
                  F_CANCELALL: begin
                     scan_in  = PW'(1);
                     state_in = S_SCAN;
                  end
                  F_FREE, F_INIT, F_SETTIME, F_CANCEL: begin
                     state_in = req_idx_ok ? S_META : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_META: begin
            meta_in  = meta_rd;
            state_in = S_DONE;
            case (func_ff)
               F_INIT: begin
                  meta_we        = 1'b1;
                  meta_wd        = meta_rd;
                  meta_wd.mark   = mark_ff;
                  meta_wd.buffer = buf_ff;
                  meta_wd.data   = dat_ff;
               end
               F_FREE: begin
                  if (meta_rd.status == ST_RUN) begin
                     link_ra  = e_ff;
                     state_in = S_UL_NEXT;
                  end else begin
                     meta_we        = 1'b1;
                     meta_wd        = meta_rd;
                     meta_wd.status = ST_FREE;
                  end
               end
               F_CANCEL: begin
                  if (meta_rd.status == ST_RUN) begin
                     ok_in    = 1'b1;
                     link_ra  = e_ff;
                     state_in = S_UL_NEXT;
                  end
               end
               F_SETTIME: begin
                  if (meta_rd.status != ST_RUN) begin
                     ok_in          = 1'b1;
                     dl_we          = 1'b1;
                     meta_we        = 1'b1;
                     meta_wd        = meta_rd;
                     meta_wd.status = ST_RUN;
                     if (alu_out.le) begin
                        // new front of the list
                        link_we      = 1'b1;
                        link_wd      = head_ff;
                        head_in      = e_ff;
                        head_time_in = when_ff;
                     end else begin
                        p_in     = head_ff;
                        link_ra  = head_ff;
                        state_in = S_INS_LINK;
                     end
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_INS_LINK: begin
            // successor of p arrives, fetch its deadline
            t_in     = link_rd;
            dl_ra    = link_rd;
            state_in = S_INS_DL;
         end
         S_INS_DL: begin
            if (alu_out.le || (t_ff == '0)) begin
               link_we  = 1'b1;
               link_wa  = p_ff;
               link_wd  = e_ff;
               state_in = S_INS_W2;
            end else begin
               p_in     = t_ff;
               link_ra  = t_ff;
               state_in = S_INS_LINK;
            end
         end
         S_INS_W2: begin
            link_we  = 1'b1;
            link_wa  = e_ff;
            link_wd  = t_ff;
            state_in = S_DONE;
         end
         S_UL_NEXT: begin
            // successor of the entry being unlinked
            ne_in = link_rd;
            if (e_ff == head_ff) begin
               head_in  = link_rd;
               dl_ra    = link_rd;
               state_in = S_UL_HT;
            end else begin
               p_in     = head_ff;
               link_ra  = head_ff;
               state_in = S_UL_WALK;
            end
         end
         S_UL_HT: begin
            head_time_in = dl_rd;
            state_in     = S_UL_FIN;
         end
         S_UL_WALK: begin
            // link_rd is the successor of p
            if (link_rd == e_ff) begin
               link_we  = 1'b1;
               link_wa  = p_ff;
               link_wd  = ne_ff;
               state_in = S_UL_FIN;
            end else if (p_ff == '0) begin
               state_in = S_UL_FIN;
            end else begin
               p_in    = link_rd;
               link_ra = link_rd;
            end
         end
         S_UL_FIN: begin
            meta_we        = 1'b1;
            meta_wd        = meta_ff;
            meta_wd.status = (func_ff == F_CANCEL) ? ST_ALLOC : ST_FREE;
            state_in       = S_DONE;
            if ((func_ff == F_CANCELALL) && (e_ff != LAST)) begin
               scan_in  = e_ff + 1'b1;
               sv_in    = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // reads run one entry ahead of the decision
            meta_ra = scan_ff;
            scan_in = scan_ff + 1'b1;
            sa_in   = scan_ff;
            sv_in   = 1'b1;
            if (sv_ff) begin
               if (func_ff == F_ALLOC) begin
                  if (meta_rd.status == ST_FREE) begin
                     meta_we        = 1'b1;
                     meta_wa        = sa_ff;
                     meta_wd        = meta_rd;
                     meta_wd.status = ST_ALLOC;
                     meta_wd.mark   = 1'b0;
                     ok_in          = 1'b1;
                     got_in         = sa_ff;
                     state_in       = S_DONE;
                  end else if (sa_ff == LAST) begin
                     state_in = S_DONE;
                  end
               end else begin
                  if (hit && (meta_rd.status == ST_RUN)) begin
                     e_in     = sa_ff;
                     meta_in  = meta_rd;
                     link_ra  = sa_ff;
                     state_in = S_UL_NEXT;
                  end else begin
                     if (hit) begin
                        meta_we        = 1'b1;
                        meta_wa        = sa_ff;
                        meta_wd        = meta_rd;
                        meta_wd.status = ST_FREE;
                     end
                     if (sa_ff == LAST) begin
                        state_in = S_DONE;
                     end
                  end
               end
            end
         end
         S_DONE: begin
            // wait for room in the result register
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               rsp_got_in   = got_ff;
               rsp_head_in  = head_ff;
               rsp_time_in  = head_time_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         sv_ff        <= 1'b0;
         head_ff      <= '0;
         head_time_ff <= NEVER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sv_ff        <= sv_in;
         head_ff      <= head_in;
         head_time_ff <= head_time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      buf_ff      <= buf_in;
      dat_ff      <= dat_in;
      mark_ff     <= mark_in;
      when_ff     <= when_in;
      e_ff        <= e_in;
      meta_ff     <= meta_in;
      p_ff        <= p_in;
      ne_ff       <= ne_in;
      t_ff        <= t_in;
      scan_ff     <= scan_in;
      sa_ff       <= sa_in;
      ok_ff       <= ok_in;
      got_ff      <= got_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_got_ff  <= rsp_got_in;
      rsp_head_ff <= rsp_head_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_got_index     = IW'(rsp_got_ff);
   assign rsp_head_index    = IW'(rsp_head_ff);
   assign rsp_head_deadline = rsp_time_ff;

   // a result only appears out of the finishing step
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_DONE))
      else $error("result raised outside finishing step");

   // an accepted item always starts work
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item left sequencer idle");

   // the sentinel is never unlinked
   a_no_sentinel_unlink: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UL_WALK || state_ff == S_UL_NEXT) |-> (e_ff != '0))
      else $error("unlink of sentinel entry");

endmodule
